// ===== rtl/iut_pkg.sv =====
// ----------------------------------------------------------------------------
// iut_pkg
// shared constants, request codes and controller states for the interval table
// ----------------------------------------------------------------------------
package iut_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int POS_BITS      = 31;
  localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
  localparam int ENTRY_BITS    = 2 * POS_BITS;

  localparam logic [1:0] MODE_ADD       = 2'd0;
  localparam logic [1:0] MODE_INTERSECT = 2'd1;
  localparam logic [1:0] MODE_SUBSET    = 2'd2;
  localparam logic [1:0] MODE_TRIM      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SETUP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_WRITE_S,
    ST_RESP
  } iut_state_t;

endpackage

// ===== rtl/interval_union_table.sv =====
// ----------------------------------------------------------------------------
// interval_union_table
// sorted table of disjoint half-open intervals with add, query and trim
// ----------------------------------------------------------------------------
// operation: add and trim scan the entries one by one and then move the tail
//   of the sorted row; intersect and subset queries only scan
// throughput: one request at a time, set by the single entry ram read port
//   used by the linear scan and by the shift of the sorted row
// reset: synchronous active-low rst_n empties the table (count to zero);
//   ram contents are not cleared and entries above the count are never read
module interval_union_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [iut_pkg::POS_BITS-1:0]   in_begin_pos,
  input  logic [iut_pkg::POS_BITS-1:0]   in_end_pos,
  input  logic [iut_pkg::POS_BITS-1:0]   in_trim_pos,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_answer_hit,
  output logic                           out_add_dropped,
  output logic [iut_pkg::CNT_BITS-1:0]   out_regions_held
);

  localparam int PB = iut_pkg::POS_BITS;
  localparam int CB = iut_pkg::CNT_BITS;
  localparam int IB = iut_pkg::IDX_BITS;
  localparam int EB = iut_pkg::ENTRY_BITS;
  localparam logic [CB-1:0] MAX_CNT = CB'(iut_pkg::MAX_INTERVALS);
  localparam logic [CB-1:0] ONE_CNT = CB'(1);

  iut_pkg::iut_state_t state_r, state_nxt;

  // entry ram: {start, end}, one write and one registered read per cycle
  logic [EB-1:0] mem [iut_pkg::MAX_INTERVALS];
  logic [EB-1:0] rdata_r;
  logic          re, we;
  logic [IB-1:0] raddr, waddr;
  logic [EB-1:0] wdata;
  logic [PB-1:0] rd_start, rd_end;

  // request and working registers
  logic [1:0]    mode_r;
  logic [PB-1:0] b_r, e_r;
  logic [PB:0]   thr_r;          // scan threshold, one extra bit for trim + 1
  logic          strict_r;       // end > thr when set, end >= thr otherwise
  logic          phase_b_r;      // add: second scan for the end side
  logic [CB-1:0] idx_r;
  logic [CB-1:0] s_r, k_r;
  logic [PB-1:0] s_start_r, k_start_r, k_end_r;
  logic          s_valid_r, k_valid_r;
  logic [CB-1:0] count_r;
  logic [CB-1:0] mv_j_r, mv_n_r, mv_delta_r;
  logic          mv_up_r;
  logic [PB-1:0] nb_r, ne_r;
  logic          hit_r, drop_r;
  logic          out_valid_r, out_hit_r, out_drop_r;
  logic [CB-1:0] out_cnt_r;

  // scan result
  logic scan_cond, scan_end, scan_hit, found;

  // setup math
  logic          k_merge;
  logic [CB-1:0] kk, tail;
  logic          add_drop;

  assign rd_start = rdata_r[EB-1:PB];
  assign rd_end   = rdata_r[PB-1:0];

  assign scan_cond = strict_r ? ({1'b0, rd_end} > thr_r) : ({1'b0, rd_end} >= thr_r);
  assign scan_end  = (state_r == iut_pkg::ST_SCAN_RD) && (idx_r == count_r);
  assign scan_hit  = (state_r == iut_pkg::ST_SCAN_CHK) && scan_cond;
  assign found     = scan_end || scan_hit;

  // end side merges when the next interval starts at or before the new end
  assign k_merge  = k_valid_r && (k_start_r <= e_r);
  assign kk       = (mode_r == iut_pkg::MODE_TRIM) ? k_r : (k_r + CB'(k_merge));
  assign tail     = count_r - kk;
  assign add_drop = (kk == s_r) && (count_r >= MAX_CNT);

  assign in_ready         = (state_r == iut_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_answer_hit   = out_hit_r;
  assign out_add_dropped  = out_drop_r;
  assign out_regions_held = out_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iut_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == iut_pkg::MODE_ADD && in_begin_pos >= in_end_pos) begin
            state_nxt = iut_pkg::ST_RESP;
          end else begin
            state_nxt = iut_pkg::ST_SCAN_RD;
          end
        end
      end
      iut_pkg::ST_SCAN_RD, iut_pkg::ST_SCAN_CHK: begin
        if (found) begin
          case (mode_r)
            iut_pkg::MODE_ADD:  state_nxt = phase_b_r ? iut_pkg::ST_SETUP
                                                      : iut_pkg::ST_SCAN_RD;
            iut_pkg::MODE_TRIM: state_nxt = iut_pkg::ST_SETUP;
            default:            state_nxt = iut_pkg::ST_RESP;
          endcase
        end else if (state_r == iut_pkg::ST_SCAN_RD) begin
          state_nxt = iut_pkg::ST_SCAN_CHK;
        end else begin
          state_nxt = iut_pkg::ST_SCAN_RD;
        end
      end
      iut_pkg::ST_SETUP: begin
        if (mode_r == iut_pkg::MODE_ADD && add_drop) begin
          state_nxt = iut_pkg::ST_RESP;
        end else begin
          state_nxt = iut_pkg::ST_MOVE_RD;
        end
      end
      iut_pkg::ST_MOVE_RD: begin
        if (mv_n_r == '0) begin
          state_nxt = (mode_r == iut_pkg::MODE_ADD) ? iut_pkg::ST_WRITE_S
                                                    : iut_pkg::ST_RESP;
        end else begin
          state_nxt = iut_pkg::ST_MOVE_WR;
        end
      end
      iut_pkg::ST_MOVE_WR: state_nxt = iut_pkg::ST_MOVE_RD;
      iut_pkg::ST_WRITE_S: state_nxt = iut_pkg::ST_RESP;
      iut_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = iut_pkg::ST_IDLE;
      end
      default: state_nxt = iut_pkg::ST_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx_r[IB-1:0];
    waddr = s_r[IB-1:0];
    wdata = {nb_r, ne_r};
    unique case (state_r)
      iut_pkg::ST_SCAN_RD: begin
        re    = (idx_r != count_r);
        raddr = idx_r[IB-1:0];
      end
      iut_pkg::ST_MOVE_RD: begin
        re    = (mv_n_r != '0);
        raddr = mv_j_r[IB-1:0];
      end
      iut_pkg::ST_MOVE_WR: begin
        we    = 1'b1;
        waddr = mv_up_r ? IB'(mv_j_r + ONE_CNT) : IB'(mv_j_r - mv_delta_r);
        wdata = rdata_r;
      end
      iut_pkg::ST_WRITE_S: begin
        we    = 1'b1;
        waddr = s_r[IB-1:0];
        wdata = {nb_r, ne_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iut_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == iut_pkg::ST_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == iut_pkg::ST_SETUP) begin
        if (mode_r == iut_pkg::MODE_TRIM) begin
          count_r <= tail;
        end else if (!add_drop) begin
          count_r <= s_r + ONE_CNT + tail;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == iut_pkg::ST_RESP && (!out_valid_r || out_ready)) begin
      out_hit_r  <= hit_r;
      out_drop_r <= drop_r;
      out_cnt_r  <= count_r;
    end
    case (state_r)
      iut_pkg::ST_IDLE: begin
        mode_r    <= in_mode;
        b_r       <= in_begin_pos;
        e_r       <= in_end_pos;
        idx_r     <= '0;
        phase_b_r <= 1'b0;
        hit_r     <= 1'b0;
        drop_r    <= 1'b0;
        case (in_mode)
          iut_pkg::MODE_ADD: begin
            thr_r    <= {1'b0, in_begin_pos};
            strict_r <= 1'b0;
          end
          iut_pkg::MODE_TRIM: begin
            thr_r    <= {1'b0, in_trim_pos} + (PB+1)'(1);
            strict_r <= 1'b1;
          end
          default: begin
            thr_r    <= {1'b0, in_begin_pos};
            strict_r <= 1'b1;
          end
        endcase
      end
      iut_pkg::ST_SCAN_RD, iut_pkg::ST_SCAN_CHK: begin
        if (found) begin
          case (mode_r)
            iut_pkg::MODE_ADD: begin
              if (!phase_b_r) begin
                s_r       <= idx_r;
                s_start_r <= rd_start;
                s_valid_r <= scan_hit;
                phase_b_r <= 1'b1;
                thr_r     <= {1'b0, e_r};
                strict_r  <= 1'b1;
              end else begin
                k_r       <= idx_r;
                k_start_r <= rd_start;
                k_end_r   <= rd_end;
                k_valid_r <= scan_hit;
              end
            end
            iut_pkg::MODE_TRIM: k_r <= idx_r;
            iut_pkg::MODE_INTERSECT: hit_r <= scan_hit && (rd_start < e_r);
            default: hit_r <= scan_hit && (rd_end >= e_r) && (rd_start <= b_r);
          endcase
        end else if (state_r == iut_pkg::ST_SCAN_CHK) begin
          idx_r <= idx_r + ONE_CNT;
        end
      end
      iut_pkg::ST_SETUP: begin
        drop_r <= (mode_r == iut_pkg::MODE_ADD) && add_drop;
        nb_r   <= (s_valid_r && s_start_r < b_r) ? s_start_r : b_r;
        ne_r   <= k_merge ? k_end_r : e_r;
        mv_n_r <= tail;
        if (mode_r == iut_pkg::MODE_TRIM) begin
          mv_up_r    <= 1'b0;
          mv_delta_r <= kk;
          mv_j_r     <= kk;
        end else if (kk == s_r) begin
          // new entry opens a slot: shift the tail up, last entry first
          mv_up_r    <= 1'b1;
          mv_delta_r <= '0;
          mv_j_r     <= count_r - ONE_CNT;
        end else begin
          // merged entries collapse: shift the tail down, first entry first
          mv_up_r    <= 1'b0;
          mv_delta_r <= kk - s_r - ONE_CNT;
          mv_j_r     <= kk;
        end
      end
      iut_pkg::ST_MOVE_WR: begin
        mv_n_r <= mv_n_r - ONE_CNT;
        mv_j_r <= mv_up_r ? (mv_j_r - ONE_CNT) : (mv_j_r + ONE_CNT);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/iut_checker.sv =====
// ----------------------------------------------------------------------------
// iut_checker
// port-level checks on the interval table request and result channels
// ----------------------------------------------------------------------------
module iut_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_answer_hit,
  input logic                         out_add_dropped,
  input logic [iut_pkg::CNT_BITS-1:0] out_regions_held
);

  localparam logic [iut_pkg::CNT_BITS-1:0] MAX_CNT = iut_pkg::CNT_BITS'(iut_pkg::MAX_INTERVALS);

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_regions_held))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_regions_held <= MAX_CNT)
    else $error("region count above table size");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_add_dropped |-> out_regions_held == MAX_CNT && !out_answer_hit)
    else $error("dropped add with table not full");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind interval_union_table iut_checker u_iut_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_answer_hit   (out_answer_hit),
  .out_add_dropped  (out_add_dropped),
  .out_regions_held (out_regions_held)
);
